// ===== rtl/zcpm_pkg.sv =====
// Shared types and constants for the zero-crossing period meter.
// Depends on nothing; every other file of the block imports it.
package zcpm_pkg;

  localparam int FILTER_ORDER = 4;
  localparam int NUM_COEFS    = 2 * FILTER_ORDER + 1;
  localparam int HIST_IDX_W   = $clog2(FILTER_ORDER);
  localparam int COEF_IDX_W   = $clog2(NUM_COEFS);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_PERIODS_TO_AVERAGE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PERIODS_INVERSE    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_NUM_0_1       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_NUM_2_3       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_NUM4_DEN1     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_DEN_2_3       = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_DEN_4         = 3'd6;

  localparam logic [7:0]  PTA_RESET  = 8'd16;
  localparam logic [16:0] PINV_RESET = 17'd4096;

  typedef logic signed [15:0] sample_t;
  typedef logic [31:0]        word_t;
  typedef logic signed [31:0] coef_t;
  typedef logic signed [39:0] yval_t;

  localparam word_t ONE_Q16 = 32'h0001_0000;
  localparam word_t TWO_Q16 = 32'h0002_0000;

  // Shared multiplier: signed 33 x signed 21
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 21;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Serial divider
  localparam int DIVIDEND_W = 49;
  localparam int DIVISOR_W  = 32;
  localparam int STEP_W     = 6;
  localparam logic [STEP_W-1:0]     DIV_STEPS_LEFT = 6'd32;
  localparam logic [STEP_W-1:0]     DIV_STEPS_FULL = 6'd49;
  localparam logic [DIVIDEND_W-1:0] RECIP_NUM = 49'h1_0000_0000_0000;
  localparam logic [DIVIDEND_W-1:0] PHASE_NUM = 49'h0_C90F_DAA2_2169;

  // Multiply-accumulate term slots
  localparam logic [COEF_IDX_W-1:0] TERM_MEAN    = 4'd0;
  localparam logic [COEF_IDX_W-1:0] TERM_A0      = 4'd1;
  localparam logic [COEF_IDX_W-1:0] TERM_X_FIRST = 4'd2;
  localparam logic [COEF_IDX_W-1:0] TERM_Y_FIRST = 4'd6;
  localparam logic [COEF_IDX_W-1:0] TERM_LAST    = 4'd9;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage

// ===== rtl/zcpm_if.sv =====
// Channel interfaces of the period meter: sample in, result out, config write.
// Depends on zcpm_pkg.
interface zcpm_sample_if;
  import zcpm_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface zcpm_result_if;
  import zcpm_pkg::*;
  logic  valid;
  logic  ready;
  word_t period;
  word_t period_inverse;
  word_t phase_step;
  modport source (output valid, output period, output period_inverse, output phase_step,
                  input ready);
  modport sink   (input valid, input period, input period_inverse, input phase_step,
                  output ready);
endinterface

interface zcpm_cfg_if;
  import zcpm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/zcpm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on zcpm_pkg.
module zcpm_mul (
  input  logic                                  clk,
  input  logic signed [zcpm_pkg::MUL_A_W-1:0]   a,
  input  logic signed [zcpm_pkg::MUL_B_W-1:0]   b,
  output logic signed [zcpm_pkg::MUL_P_W-1:0]   p
);
  import zcpm_pkg::*;

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

// ===== rtl/zcpm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on zcpm_pkg (widths and the command struct).
module zcpm_div (
  input  logic                                clk,
  input  logic                                rst,
  input  zcpm_pkg::div_cmd_t                  cmd,
  input  logic [zcpm_pkg::DIVIDEND_W-1:0]     dividend,
  input  logic [zcpm_pkg::DIVISOR_W-1:0]      divisor,
  output logic                                busy,
  output logic                                done,
  output logic [zcpm_pkg::DIVIDEND_W-1:0]     quotient
);
  import zcpm_pkg::*;

  logic [DIVISOR_W-1:0]  rem;
  logic [DIVIDEND_W-1:0] dq;
  logic [DIVISOR_W-1:0]  den;
  logic [STEP_W-1:0]     cnt;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Shift the next dividend bit into the partial remainder and try a subtract
  assign trial = {rem, dq[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, den};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= cmd.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= '0;
      dq  <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      dq  <= {dq[DIVIDEND_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

// ===== rtl/zero_crossing_period_meter.sv =====
// Top level of the zero-crossing period meter: sequencer, state and config registers.
// Depends on zcpm_pkg, zcpm_if, zcpm_mul and zcpm_div.
//
// Usage:
//   samples : one signed 16-bit sample per transaction (valid/ready).
//   results : period (Q16.16), period_inverse (Q0.32), phase_step (Q3.29),
//             one transaction after every periods_to_average rising crossings.
//   cfg     : register writes by index; always ready, write only while idle.
// Per sample transaction:
//   - no rising crossing: the sequencer stays idle, ready again the next cycle.
//   - crossing, no result due: the crossing fraction goes
//     through the serial divider at one quotient bit per cycle (32 bits).
//   - crossing that completes an average: the mean and the nine filter
//     terms each pass S_MUL_HI, S_MUL_LO, S_MUL_ADD and S_MUL_ACC on the shared
//     multiplier, then two 49-step divisions form the reciprocal and the phase step.
// The result sits in an output register; the block keeps taking samples while
// it waits. If a new result is ready while the old one is still stalled, the
// sequencer holds in its emit state until the receiver takes the old one.
// Reset (synchronous, active high) clears all history, sums and counters,
// drops any pending result and loads the register defaults.
module zero_crossing_period_meter (
  input  logic                 clk,
  input  logic                 rst,
  zcpm_sample_if.sink          samples,
  zcpm_result_if.source        results,
  zcpm_cfg_if.sink             cfg
);
  import zcpm_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0_0000_0000_0001,
    S_DIVL    = 13'b0_0000_0000_0010,
    S_ACC     = 13'b0_0000_0000_0100,
    S_MUL_HI  = 13'b0_0000_0000_1000,
    S_MUL_LO  = 13'b0_0000_0001_0000,
    S_MUL_ADD = 13'b0_0000_0010_0000,
    S_MUL_ACC = 13'b0_0000_0100_0000,
    S_SAT     = 13'b0_0000_1000_0000,
    S_RSTART  = 13'b0_0001_0000_0000,
    S_RECIP   = 13'b0_0010_0000_0000,
    S_PSTART  = 13'b0_0100_0000_0000,
    S_PHASE   = 13'b0_1000_0000_0000,
    S_EMIT    = 13'b1_0000_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [7:0]  pta;
  logic [16:0] pinv;
  coef_t       coef [NUM_COEFS];

  // Measurement state
  sample_t     prev;
  word_t       ssc;
  word_t       per;
  logic [39:0] sum;
  logic [7:0]  counter;
  word_t       xh [FILTER_ORDER];
  yval_t       yh [FILTER_ORDER];

  // Datapath registers
  word_t                  xin;
  logic signed [47:0]     acc;
  logic signed [73:0]     prod;
  logic [COEF_IDX_W-1:0]  k;
  word_t                  pval;
  word_t                  inv_res;
  word_t                  phase_res;
  logic                   out_valid;
  word_t                  out_period;
  word_t                  out_inv;
  word_t                  out_phase;

  // Handshakes
  logic in_fire;
  logic crossing;
  assign samples.ready = (state == S_IDLE);
  assign in_fire       = samples.valid && samples.ready;
  assign crossing      = prev[15] && !samples.sample[15];
  assign cfg.ready     = 1'b1;

  // Crossing fraction: floor((-prev << 16) / (cur - prev))
  logic [15:0] neg_prev;
  logic [16:0] span;
  assign neg_prev = 16'(-prev);
  assign span     = {samples.sample[15], samples.sample} - {prev[15], prev};

  // Divider control
  div_cmd_t                div_cmd;
  logic [DIVIDEND_W-1:0]   div_dividend;
  logic [DIVISOR_W-1:0]    div_divisor;
  logic                    div_busy;
  logic                    div_done;
  logic [DIVIDEND_W-1:0]   div_q;
  word_t                   div_q_sat;

  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.steps = DIV_STEPS_FULL;
    div_dividend  = RECIP_NUM;
    div_divisor   = pval;
    case (state)
      S_IDLE: begin
        div_cmd.start = in_fire && crossing;
        div_cmd.steps = DIV_STEPS_LEFT;
        div_dividend  = {neg_prev, 16'h0000, 17'h0_0000};
        div_divisor   = {16'h0000, span[15:0]};
      end
      S_RSTART: begin
        div_cmd.start = 1'b1;
      end
      S_PSTART: begin
        div_cmd.start = 1'b1;
        div_dividend  = PHASE_NUM;
      end
      default: ;
    endcase
  end

  zcpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .cmd      (div_cmd),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_q_sat = (|div_q[DIVIDEND_W-1:32]) ? '1 : div_q[31:0];

  // Multiplier operands: value split into a signed high chunk and an unsigned
  // low chunk of 20 bits, so each term is (c * hi) << 20 + c * lo exactly.
  logic signed [40:0]         opv;
  logic [COEF_IDX_W-1:0]      ci;
  logic [HIST_IDX_W-1:0]      xi;
  logic [HIST_IDX_W-1:0]      yi;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [MUL_P_W-1:0]  mul_p;

  assign xi = HIST_IDX_W'(k - TERM_X_FIRST);
  assign yi = HIST_IDX_W'(k - TERM_Y_FIRST);
  assign ci = (k == TERM_MEAN) ? '0 : k - 1'b1;

  always_comb begin
    if (k == TERM_MEAN) begin
      opv = {1'b0, sum};
    end else if (k == TERM_A0) begin
      opv = {9'b0, xin};
    end else if (k < TERM_Y_FIRST) begin
      opv = {9'b0, xh[xi]};
    end else begin
      opv = {yh[yi][39], yh[yi]};
    end
  end

  assign mul_a = (k == TERM_MEAN) ? {16'b0, pinv} : {coef[ci][31], coef[ci]};
  assign mul_b = (state == S_MUL_LO) ? {1'b0, opv[19:0]} : opv[40:20];

  zcpm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Per-term floor(c * v / 2^30)
  logic signed [43:0] term;
  logic [47:0]        term_ext;
  assign term     = prod[73:30];
  assign term_ext = {{4{term[43]}}, term};

  // Period and sum update
  logic [33:0] per_raw;
  logic [40:0] sum_raw;
  logic [32:0] ssc_inc;
  logic [7:0]  counter_next;
  assign per_raw      = {2'b0, ssc} + {17'b0, div_q[16:0]} - {2'b0, ONE_Q16};
  assign sum_raw      = {1'b0, sum} + {9'b0, per};
  assign ssc_inc      = {1'b0, ssc} + {1'b0, ONE_Q16};
  assign counter_next = counter + 8'd1;

  // Filter output saturation and period clamp
  yval_t y_sat;
  word_t p_clamp;
  always_comb begin
    if ((&acc[47:39]) || !(|acc[47:39])) begin
      y_sat = acc[39:0];
    end else if (acc[47]) begin
      y_sat = {1'b1, 39'b0};
    end else begin
      y_sat = {1'b0, {39{1'b1}}};
    end
    if (y_sat[39]) begin
      p_clamp = '0;
    end else if (|y_sat[38:32]) begin
      p_clamp = '1;
    end else begin
      p_clamp = y_sat[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (in_fire && crossing) state_next = S_DIVL;
      S_DIVL:    if (div_done) state_next = S_ACC;
      S_ACC:     state_next = (counter_next >= pta) ? S_MUL_HI : S_IDLE;
      S_MUL_HI:  state_next = S_MUL_LO;
      S_MUL_LO:  state_next = S_MUL_ADD;
      S_MUL_ADD: state_next = S_MUL_ACC;
      S_MUL_ACC: state_next = (k == TERM_LAST) ? S_SAT : S_MUL_HI;
      S_SAT:     state_next = S_RSTART;
      S_RSTART:  state_next = S_RECIP;
      S_RECIP:   if (div_done) state_next = S_PSTART;
      S_PSTART:  state_next = S_PHASE;
      S_PHASE:   if (div_done) state_next = S_EMIT;
      S_EMIT:    if (!out_valid || results.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pta  <= PTA_RESET;
      pinv <= PINV_RESET;
      for (int i = 0; i < NUM_COEFS; i++) begin
        coef[i] <= '0;
      end
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PERIODS_TO_AVERAGE: pta  <= cfg.data[7:0];
        REG_PERIODS_INVERSE:    pinv <= cfg.data[16:0];
        REG_COEF_NUM_0_1: begin
          coef[0] <= cfg.data[31:0];
          coef[1] <= cfg.data[63:32];
        end
        REG_COEF_NUM_2_3: begin
          coef[2] <= cfg.data[31:0];
          coef[3] <= cfg.data[63:32];
        end
        REG_COEF_NUM4_DEN1: begin
          coef[4] <= cfg.data[31:0];
          coef[5] <= cfg.data[63:32];
        end
        REG_COEF_DEN_2_3: begin
          coef[6] <= cfg.data[31:0];
          coef[7] <= cfg.data[63:32];
        end
        REG_COEF_DEN_4: coef[8] <= cfg.data[31:0];
        default: ;
      endcase
    end
  end

  // Measurement and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev    <= '0;
      ssc     <= '0;
      sum     <= '0;
      counter <= '0;
      k       <= TERM_MEAN;
      for (int i = 0; i < FILTER_ORDER; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            prev <= samples.sample;
            // Advance the sample count; a crossing reloads it once the fraction is known
            if (!crossing) begin
              ssc <= ssc_inc[32] ? '1 : ssc_inc[31:0];
            end
          end
        end
        S_DIVL: begin
          if (div_done) begin
            ssc <= TWO_Q16 - {15'b0, div_q[16:0]};
          end
        end
        S_ACC: begin
          sum     <= sum_raw[40] ? '1 : sum_raw[39:0];
          counter <= counter_next;
          k       <= TERM_MEAN;
        end
        S_MUL_ACC: begin
          if (k != TERM_LAST) begin
            k <= k + 1'b1;
          end
        end
        S_SAT: begin
          for (int i = FILTER_ORDER - 1; i > 0; i--) begin
            xh[i] <= xh[i-1];
            yh[i] <= yh[i-1];
          end
          xh[0]   <= xin;
          yh[0]   <= y_sat;
          sum     <= '0;
          counter <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (state)
      S_DIVL: begin
        // Elapsed period, clamped at zero
        if (div_done) begin
          per <= per_raw[33] ? '0 : per_raw[31:0];
        end
      end
      S_MUL_LO:  prod <= {mul_p, 20'b0};
      S_MUL_ADD: prod <= prod + {{20{mul_p[MUL_P_W-1]}}, mul_p};
      S_MUL_ACC: begin
        if (k == TERM_MEAN) begin
          xin <= (|prod[73:48]) ? '1 : prod[47:16];
          acc <= '0;
        end else if (k >= TERM_Y_FIRST) begin
          acc <= acc - term_ext;
        end else begin
          acc <= acc + term_ext;
        end
      end
      S_SAT:   pval <= p_clamp;
      S_RECIP: if (div_done) inv_res <= div_q_sat;
      S_PHASE: if (div_done) phase_res <= div_q_sat;
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || results.ready)) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || results.ready)) begin
      out_period <= pval;
      out_inv    <= inv_res;
      out_phase  <= phase_res;
    end
  end

  assign results.valid          = out_valid;
  assign results.period         = out_period;
  assign results.period_inverse = out_inv;
  assign results.phase_step     = out_phase;

`ifndef ASSERT_OFF
  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !div_busy)
    else $error("sample ready while divider busy");

  a_plain_sample_one_cycle: assert property (@(posedge clk) disable iff (rst)
    in_fire && !crossing |=> state == S_IDLE)
    else $error("non-crossing sample left the idle state");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == S_EMIT))
    else $error("result raised outside the emit state");

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVL || state == S_RECIP || state == S_PHASE))
    else $error("divider finished with no consumer waiting");

  a_all_terms_done: assert property (@(posedge clk) disable iff (rst)
    state == S_SAT |-> k == TERM_LAST)
    else $error("filter saturation before all terms accumulated");
`endif

endmodule
